>>> src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked during reset too
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/spq_pkg.sv
package spq_pkg;

    localparam int STATUS_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } spq_status_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } spq_op_t;

    typedef struct packed {
        logic ins;
        logic rem;
    } spq_ctrl_t;

endpackage

>>> src/spq_cell.sv
module spq_cell #(
    parameter int IDX        = 0,
    parameter int CNT_W      = 5,
    parameter int DATA_WIDTH = 16,
    parameter int PRIO_WIDTH = 8
) (
    input  logic                  aclk,
    input  spq_pkg::spq_ctrl_t    ctrl,
    input  logic [CNT_W-1:0]      count,
    input  logic [DATA_WIDTH-1:0] ins_data,
    input  logic [PRIO_WIDTH-1:0] new_prio,
    input  logic                  left_le,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [PRIO_WIDTH-1:0] left_prio,
    input  logic [DATA_WIDTH-1:0] right_data,
    input  logic [PRIO_WIDTH-1:0] right_prio,
    output logic                  le,
    output logic [DATA_WIDTH-1:0] data,
    output logic [PRIO_WIDTH-1:0] prio
);
    import spq_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg, data_next;
    logic [PRIO_WIDTH-1:0] prio_reg, prio_next;
    logic                  occ;

    assign occ  = count > CNT_W'(IDX);
    assign le   = occ && (prio_reg <= new_prio);
    assign data = data_reg;
    assign prio = prio_reg;

    always_comb begin
        data_next = data_reg;
        prio_next = prio_reg;
        if (ctrl.ins && !le) begin
            if (left_le) begin
                data_next = ins_data;
                prio_next = new_prio;
            end else begin
                data_next = left_data;
                prio_next = left_prio;
            end
        end else if (ctrl.rem) begin
            data_next = right_data;
            prio_next = right_prio;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        prio_reg <= prio_next;
    end

endmodule

>>> src/sorted_priority_queue.sv
// channel | dir | tdata (low bit up)                      | tuser
// s_axis  | in  | item_data, item_priority                | mode
// m_axis  | out | head_data, head_priority, fill_count    | status
//
// One word per cycle while s_axis_tready is high: every cell compares the new
// priority in parallel, and cells shift one place toward a neighbor on insert or remove.
// The result sits in an output register; s_axis_tready drops only while
// that register is full and m_axis_tready is low.
// Reset clears the fill count and the output valid; cell contents are not reset.
module sorted_priority_queue #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 16,
    parameter int PRIO_WIDTH = 8,
    localparam int CNT_W     = $clog2(DEPTH + 1),
    localparam int IN_W      = ((DATA_WIDTH + PRIO_WIDTH + 7) / 8) * 8,
    localparam int OUT_W     = ((DATA_WIDTH + PRIO_WIDTH + CNT_W + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [IN_W-1:0]               s_axis_tdata,  // item_data, item_priority
    input  logic                          s_axis_tuser,  // mode
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [OUT_W-1:0]              m_axis_tdata,  // head_data, head_priority, fill_count
    output logic [spq_pkg::STATUS_W-1:0]  m_axis_tuser   // status
);
    import spq_pkg::*;

    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]      m_data_reg, m_data_next;
    spq_status_t           m_status_reg, m_status_next;

    logic                  in_acc, is_full, is_empty;
    spq_ctrl_t             ctrl;
    logic [DATA_WIDTH-1:0] ins_data;
    logic [PRIO_WIDTH-1:0] new_prio;
    logic [DATA_WIDTH-1:0] head_data;
    logic [PRIO_WIDTH-1:0] head_prio;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [PRIO_WIDTH-1:0] cell_prio [DEPTH];
    logic                  cell_le   [DEPTH];

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign ins_data      = s_axis_tdata[DATA_WIDTH-1:0];
    assign new_prio      = s_axis_tdata[DATA_WIDTH +: PRIO_WIDTH];
    assign is_full       = count_reg == CNT_W'(DEPTH);
    assign is_empty      = count_reg == '0;

    assign ctrl.ins = in_acc && (spq_op_t'(s_axis_tuser) == OP_INSERT) && !is_full;
    assign ctrl.rem = in_acc && (spq_op_t'(s_axis_tuser) == OP_REMOVE) && !is_empty;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                  l_le;
        logic [DATA_WIDTH-1:0] l_data, r_data;
        logic [PRIO_WIDTH-1:0] l_prio, r_prio;

        if (i == 0) begin : g_first
            assign l_le   = 1'b1;
            assign l_data = ins_data;
            assign l_prio = new_prio;
        end else begin : g_mid
            assign l_le   = cell_le[i-1];
            assign l_data = cell_data[i-1];
            assign l_prio = cell_prio[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign r_data = cell_data[i];
            assign r_prio = cell_prio[i];
        end else begin : g_inner
            assign r_data = cell_data[i+1];
            assign r_prio = cell_prio[i+1];
        end

        spq_cell #(
            .IDX        (i),
            .CNT_W      (CNT_W),
            .DATA_WIDTH (DATA_WIDTH),
            .PRIO_WIDTH (PRIO_WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .count      (count_reg),
            .ins_data   (ins_data),
            .new_prio   (new_prio),
            .left_le    (l_le),
            .left_data  (l_data),
            .left_prio  (l_prio),
            .right_data (r_data),
            .right_prio (r_prio),
            .le         (cell_le[i]),
            .data       (cell_data[i]),
            .prio       (cell_prio[i])
        );
    end

    assign head_data = ctrl.rem ? cell_data[0] : '0;
    assign head_prio = ctrl.rem ? cell_prio[0] : '0;

    always_comb begin
        count_next    = count_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        if (ctrl.ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.rem) begin
            count_next = count_reg - CNT_W'(1);
        end
        if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        if (in_acc) begin
            m_valid_next = 1'b1;
            m_data_next  = OUT_W'({count_next, head_prio, head_data});
            if (spq_op_t'(s_axis_tuser) == OP_INSERT) begin
                m_status_next = is_full ? ST_FULL : ST_DONE;
            end else begin
                m_status_next = is_empty ? ST_EMPTY : ST_DONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_status_reg;

endmodule

>>> src/spq_checker.sv
`include "assert_macros.svh"

module spq_checker #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 16,
    parameter int PRIO_WIDTH = 8,
    parameter int CNT_W      = 5,
    parameter int OUT_W      = 32
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [OUT_W-1:0]             m_axis_tdata,
    input logic [spq_pkg::STATUS_W-1:0] m_axis_tuser
);
    import spq_pkg::*;

    logic [CNT_W-1:0] fill;
    logic [DATA_WIDTH+PRIO_WIDTH-1:0] head;

    assign head = m_axis_tdata[DATA_WIDTH+PRIO_WIDTH-1:0];
    assign fill = m_axis_tdata[DATA_WIDTH+PRIO_WIDTH +: CNT_W];

    `ASSERT_NEXT_ALWAYS(a_reset_clears_valid, aclk, !aresetn, !m_axis_tvalid)
    `ASSERT_NEXT(a_valid_holds, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `ASSERT_IMPLY(a_full_count, aclk, aresetn,
        m_axis_tvalid && m_axis_tuser == ST_FULL, fill == CNT_W'(DEPTH) && head == '0)
    `ASSERT_IMPLY(a_empty_count, aclk, aresetn,
        m_axis_tvalid && m_axis_tuser == ST_EMPTY, fill == '0 && head == '0)
    `ASSERT_IMPLY(a_fill_bound, aclk, aresetn, m_axis_tvalid, fill <= CNT_W'(DEPTH))

endmodule

bind sorted_priority_queue spq_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .PRIO_WIDTH (PRIO_WIDTH),
    .CNT_W      (CNT_W),
    .OUT_W      (OUT_W)
) u_spq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
